FILE: rtl/spatial_hash_grid_builder_core_assert.svh
// Assertion macros for the spatial hash grid builder core.
`ifndef SPATIAL_HASH_GRID_BUILDER_CORE_ASSERT_SVH
`define SPATIAL_HASH_GRID_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SHG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/shg_pkg.sv
// Shared types and constants for the spatial hash grid builder.
package shg_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int TABLE_DEPTH   = 4096;

    localparam int DIV_W = 32;

    localparam logic [31:0] MIX_LO = 32'hed558ccd;
    localparam logic [31:0] MIX_HI = 32'hff51afd7;
    localparam int MIX_SHIFT = 33;

    localparam logic [2:0] CFG_CELL_RADIUS    = 3'd0;
    localparam logic [2:0] CFG_TABLE_SIZE     = 3'd1;
    localparam logic [2:0] CFG_PARTICLE_COUNT = 3'd2;
    localparam logic [2:0] CFG_MULT_X         = 3'd3;
    localparam logic [2:0] CFG_MULT_Y         = 3'd4;

    localparam logic [31:0] RST_CELL_RADIUS    = 32'd65536;
    localparam logic [12:0] RST_TABLE_SIZE     = 13'd2053;
    localparam logic [10:0] RST_PARTICLE_COUNT = 11'd1024;
    localparam logic [31:0] RST_MULT_X         = 32'd73856093;
    localparam logic [31:0] RST_MULT_Y         = 32'd19349663;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_SLOT  = 2'd2;
    localparam logic [1:0] MODE_START = 2'd3;

    typedef struct packed {
        logic              valid;
        logic              tag;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  dvd;
        logic [DIV_W-1:0]  dvs;
        logic [DIV_W-1:0]  quo;
    } t_div_bus;

    typedef enum logic [20:0] {
        S_CLR   = 21'h000001,
        S_IDLE  = 21'h000002,
        S_DIV   = 21'h000004,
        S_MX    = 21'h000008,
        S_MY    = 21'h000010,
        S_M0    = 21'h000020,
        S_M1    = 21'h000040,
        S_M2    = 21'h000080,
        S_MIX   = 21'h000100,
        S_MOD   = 21'h000200,
        S_RD    = 21'h000400,
        S_BCLR  = 21'h000800,
        S_CNT_A = 21'h001000,
        S_CNT_B = 21'h002000,
        S_CNT_C = 21'h004000,
        S_PRE_A = 21'h008000,
        S_PRE_B = 21'h010000,
        S_PLC_A = 21'h020000,
        S_PLC_B = 21'h040000,
        S_PLC_C = 21'h080000,
        S_DONE  = 21'h100000
    } t_state;

endpackage

FILE: rtl/shg_ram.sv
// Generic simple dual-port RAM with registered read.
module shg_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/shg_div_cell.sv
// One restoring-division cell: resolves one quotient bit per transaction.
module shg_div_cell import shg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_bus i_bus,
    output t_div_bus o_bus
);
    logic [DIV_W:0]   sh;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic             r_valid;
    t_div_bus         r_bus;

    assign sh   = {i_bus.rem, i_bus.dvd[DIV_W-1]};
    assign diff = sh - {1'b0, i_bus.dvs};
    assign ge   = (sh >= {1'b0, i_bus.dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bus.valid <= 1'b0;
        r_bus.tag   <= i_bus.tag;
        r_bus.rem   <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
        r_bus.dvd   <= {i_bus.dvd[DIV_W-2:0], 1'b0};
        r_bus.dvs   <= i_bus.dvs;
        r_bus.quo   <= {i_bus.quo[DIV_W-2:0], ge};
    end

    always_comb begin
        o_bus       = r_bus;
        o_bus.valid = r_valid;
    end
endmodule

FILE: rtl/shg_div_chain.sv
// Pipelined divider: a row of division cells, one quotient bit per cell.
module shg_div_chain import shg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_bus i_bus,
    output t_div_bus o_bus
);
    t_div_bus link [DIV_W+1];

    assign link[0] = i_bus;

    for (genvar g = 0; g < DIV_W; g++) begin : g_cell
        shg_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bus  (link[g]),
            .o_bus  (link[g+1])
        );
    end

    assign o_bus = link[DIV_W];
endmodule

FILE: rtl/spatial_hash_grid_builder_core.sv
// Top level of the spatial hash grid builder: control, hashing, stores.
// Load: x and y divides back to back, then the modulo pass, in the divider chain.
// Build: memory port walks (bucket clear, count, prefix sum, placement).
// Slot and start reads answer after a registered RAM read; out-of-range requests answer from idle.
// One transaction at a time; the receiver cannot stall the result strobe.
// After reset the start table is cleared with busy high.
`include "spatial_hash_grid_builder_core_assert.svh"
module spatial_hash_grid_builder_core import shg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_index,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic [9:0]  o_particle,
    output logic [11:0] o_cell_key,
    output logic [10:0] o_start_index,
    output logic        o_status
);
    localparam int PW = $clog2(MAX_PARTICLES);
    localparam int KW = $clog2(TABLE_DEPTH);
    localparam int SW = PW + 1;
    localparam int CW = ((PW > KW) ? PW : KW) + 1;

    t_state r_state;

    logic [31:0] r_radius;
    logic [12:0] r_tsize;
    logic [10:0] r_pcount;
    logic [31:0] r_mx;
    logic [31:0] r_my;

    logic [31:0] eff_n;
    logic [31:0] eff_m;
    logic [31:0] rad;
    logic [31:0] idx_ext;
    logic        in_range;
    logic        accept;

    logic [CW-1:0]      r_cnt;
    logic [SW-1:0]      r_run;
    logic [KW-1:0]      r_key;
    logic [31:0]        r_idx;
    logic [1:0]         r_mode;
    logic [31:0]        r_py;
    logic               r_fed;
    logic               r_gotx;
    logic signed [32:0] r_cx;
    logic signed [32:0] r_cy;
    logic [63:0]        r_acc;
    logic [63:0]        r_lo;
    logic [31:0]        r_hi;

    logic               r_strobe;
    logic [9:0]         r_particle;
    logic [11:0]        r_cell_key;
    logic [10:0]        r_start;
    logic               r_status;

    t_div_bus div_in;
    t_div_bus div_out;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    logic [32:0]        fl_mag;
    logic signed [32:0] fl_val;
    logic [63:0]        hxy;
    logic [63:0]        hmix;
    logic [63:0]        hfin;
    logic [31:0]        hs;
    logic [31:0]        key_full;
    logic               last_n;
    logic               last_d;
    logic               err_fields_zero;
    logic               div_consumer;

    logic          key_we,  bkt_we,  st_we,  ord_we;
    logic [PW-1:0] key_wa,  key_ra,  ord_wa, ord_ra;
    logic [KW-1:0] bkt_wa,  bkt_ra,  st_wa,  st_ra;
    logic [KW-1:0] key_wd,  key_rd,  srt_rd;
    logic [SW-1:0] bkt_wd,  bkt_rd,  st_wd,  st_rd;
    logic [PW-1:0] ord_wd,  ord_rd;

    assign eff_n = (r_pcount == 11'd0) ? 32'd1 :
                   ((32'(r_pcount) > 32'(MAX_PARTICLES)) ? 32'(MAX_PARTICLES)
                                                         : 32'(r_pcount));
    assign eff_m = (r_tsize == 13'd0) ? 32'd1 :
                   ((32'(r_tsize) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(r_tsize));
    assign rad     = (r_radius == 32'd0) ? 32'd1 : r_radius;
    assign idx_ext = 32'(i_index);
    assign accept  = start && !busy;
    assign last_n  = (32'(r_cnt) == (eff_n - 32'd1));
    assign last_d  = (32'(r_cnt) == 32'(TABLE_DEPTH - 1));

    always_comb begin
        case (i_mode)
            MODE_LOAD:  in_range = idx_ext < eff_n;
            MODE_BUILD: in_range = 1'b1;
            MODE_SLOT:  in_range = idx_ext < eff_n;
            MODE_START: in_range = idx_ext < eff_m;
            default:    in_range = 1'b0;
        endcase
    end

    // floor division result from the divider chain
    assign fl_mag = {1'b0, div_out.quo} + 33'((div_out.tag && div_out.rem != 32'd0) ? 1 : 0);
    assign fl_val = div_out.tag ? -$signed(fl_mag) : $signed(fl_mag);

    assign mul_p = mul_a * mul_b;
    assign hxy   = r_acc ^ mul_p[63:0];
    assign hmix  = hxy ^ {{MIX_SHIFT{hxy[63]}}, hxy[63:MIX_SHIFT]};
    assign hfin  = r_acc ^ {{MIX_SHIFT{r_acc[63]}}, r_acc[63:MIX_SHIFT]};
    assign hs    = hfin[31:0];
    assign key_full = (div_out.tag && div_out.rem != 32'd0) ? (eff_m - div_out.rem)
                                                            : div_out.rem;

    always_comb begin
        case (r_state)
            S_MX: begin
                mul_a = r_cx;
                mul_b = $signed({1'b0, r_mx});
            end
            S_MY: begin
                mul_a = r_cy;
                mul_b = $signed({1'b0, r_my});
            end
            S_M1: begin
                mul_a = $signed({1'b0, r_acc[63:32]});
                mul_b = $signed({1'b0, MIX_LO});
            end
            S_M2: begin
                mul_a = $signed({1'b0, r_acc[31:0]});
                mul_b = $signed({1'b0, MIX_HI});
            end
            default: begin
                mul_a = $signed({1'b0, r_acc[31:0]});
                mul_b = $signed({1'b0, MIX_LO});
            end
        endcase
    end

    always_comb begin
        div_in = '0;
        case (r_state)
            S_IDLE: begin
                div_in.valid = accept && in_range && (i_mode == MODE_LOAD);
                div_in.tag   = i_pos_x[31];
                div_in.dvd   = i_pos_x[31] ? (32'd0 - i_pos_x) : i_pos_x;
                div_in.dvs   = rad;
            end
            S_DIV: begin
                div_in.valid = !r_fed;
                div_in.tag   = r_py[31];
                div_in.dvd   = r_py[31] ? (32'd0 - r_py) : r_py;
                div_in.dvs   = rad;
            end
            S_MIX: begin
                div_in.valid = 1'b1;
                div_in.tag   = hs[31];
                div_in.dvd   = hs[31] ? (32'd0 - hs) : hs;
                div_in.dvs   = eff_m;
            end
            default: begin
                div_in = '0;
            end
        endcase
    end

    shg_div_chain u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_bus  (div_in),
        .o_bus  (div_out)
    );

    // memory port steering
    always_comb begin
        key_we = 1'b0;
        key_wa = r_idx[PW-1:0];
        key_wd = key_full[KW-1:0];
        key_ra = r_cnt[PW-1:0];
        bkt_we = 1'b0;
        bkt_wa = r_key;
        bkt_wd = bkt_rd + SW'(1);
        bkt_ra = key_rd;
        st_we  = 1'b0;
        st_wa  = r_cnt[KW-1:0];
        st_wd  = '1;
        st_ra  = idx_ext[KW-1:0];
        ord_we = 1'b0;
        ord_wa = bkt_rd[PW-1:0];
        ord_wd = r_cnt[PW-1:0];
        ord_ra = idx_ext[PW-1:0];
        case (r_state)
            S_CLR: begin
                st_we = 1'b1;
            end
            S_MOD: begin
                key_we = div_out.valid;
            end
            S_BCLR: begin
                bkt_we = 1'b1;
                bkt_wa = r_cnt[KW-1:0];
                bkt_wd = '0;
            end
            S_CNT_C: begin
                bkt_we = 1'b1;
            end
            S_PRE_A: begin
                bkt_ra = r_cnt[KW-1:0];
            end
            S_PRE_B: begin
                bkt_we = 1'b1;
                bkt_wa = r_cnt[KW-1:0];
                bkt_wd = r_run;
                st_we  = 1'b1;
                st_wd  = (bkt_rd != '0) ? r_run : '1;
            end
            S_PLC_C: begin
                bkt_we = 1'b1;
                ord_we = 1'b1;
            end
            default: begin
                key_we = 1'b0;
            end
        endcase
    end

    shg_ram #(.W(KW), .DEPTH(MAX_PARTICLES)) u_key_store (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_wa), .i_wdata(key_wd),
        .i_raddr(key_ra), .o_rdata(key_rd)
    );

    shg_ram #(.W(PW), .DEPTH(MAX_PARTICLES)) u_order_store (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_raddr(ord_ra), .o_rdata(ord_rd)
    );

    shg_ram #(.W(KW), .DEPTH(MAX_PARTICLES)) u_sorted_keys (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(r_key),
        .i_raddr(ord_ra), .o_rdata(srt_rd)
    );

    shg_ram #(.W(SW), .DEPTH(TABLE_DEPTH)) u_start_table (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd)
    );

    shg_ram #(.W(SW), .DEPTH(TABLE_DEPTH)) u_bucket (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(bkt_wa), .i_wdata(bkt_wd),
        .i_raddr(bkt_ra), .o_rdata(bkt_rd)
    );

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RST_CELL_RADIUS;
            r_tsize  <= RST_TABLE_SIZE;
            r_pcount <= RST_PARTICLE_COUNT;
            r_mx     <= RST_MULT_X;
            r_my     <= RST_MULT_Y;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CELL_RADIUS:    r_radius <= i_cfg_data;
                CFG_TABLE_SIZE:     r_tsize  <= i_cfg_data[12:0];
                CFG_PARTICLE_COUNT: r_pcount <= i_cfg_data[10:0];
                CFG_MULT_X:         r_mx     <= i_cfg_data;
                CFG_MULT_Y:         r_my     <= i_cfg_data;
                default:            r_radius <= r_radius;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (last_d) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx  <= idx_ext;
                        r_mode <= i_mode;
                        r_py   <= i_pos_y;
                        r_fed  <= 1'b0;
                        r_gotx <= 1'b0;
                        r_cnt  <= '0;
                        r_run  <= '0;
                        if (!in_range) begin
                            r_strobe   <= 1'b1;
                            r_particle <= '0;
                            r_cell_key <= '0;
                            r_start    <= '0;
                            r_status   <= 1'b1;
                        end else begin
                            case (i_mode)
                                MODE_LOAD:  r_state <= S_DIV;
                                MODE_BUILD: r_state <= S_BCLR;
                                default:    r_state <= S_RD;
                            endcase
                        end
                    end
                end
                S_DIV: begin
                    r_fed <= 1'b1;
                    if (div_out.valid) begin
                        if (!r_gotx) begin
                            r_cx   <= fl_val;
                            r_gotx <= 1'b1;
                        end else begin
                            r_cy    <= fl_val;
                            r_state <= S_MX;
                        end
                    end
                end
                S_MX: begin
                    r_acc   <= mul_p[63:0];
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_acc   <= hmix;
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_lo    <= mul_p[63:0];
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_hi    <= mul_p[31:0];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= {r_hi + mul_p[31:0] + r_lo[63:32], r_lo[31:0]};
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (div_out.valid) begin
                        r_strobe   <= 1'b1;
                        r_particle <= 10'(r_idx);
                        r_cell_key <= 12'(key_full[KW-1:0]);
                        r_start    <= '0;
                        r_status   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_strobe <= 1'b1;
                    r_status <= 1'b0;
                    if (r_mode == MODE_SLOT) begin
                        r_particle <= 10'(ord_rd);
                        r_cell_key <= 12'(srt_rd);
                        r_start    <= '0;
                    end else begin
                        r_particle <= '0;
                        r_cell_key <= '0;
                        r_start    <= 11'($signed(st_rd));
                    end
                    r_state <= S_IDLE;
                end
                S_BCLR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (last_d) begin
                        r_cnt   <= '0;
                        r_state <= S_CNT_A;
                    end
                end
                S_CNT_A: begin
                    r_state <= S_CNT_B;
                end
                S_CNT_B: begin
                    r_key   <= key_rd;
                    r_state <= S_CNT_C;
                end
                S_CNT_C: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_CNT_A;
                    if (last_n) begin
                        r_cnt   <= '0;
                        r_state <= S_PRE_A;
                    end
                end
                S_PRE_A: begin
                    r_state <= S_PRE_B;
                end
                S_PRE_B: begin
                    r_run   <= r_run + bkt_rd;
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_PRE_A;
                    if (last_d) begin
                        r_cnt   <= '0;
                        r_state <= S_PLC_A;
                    end
                end
                S_PLC_A: begin
                    r_state <= S_PLC_B;
                end
                S_PLC_B: begin
                    r_key   <= key_rd;
                    r_state <= S_PLC_C;
                end
                S_PLC_C: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_PLC_A;
                    if (last_n) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_strobe   <= 1'b1;
                    r_particle <= '0;
                    r_cell_key <= '0;
                    r_start    <= '0;
                    r_status   <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_particle    = r_particle;
    assign o_cell_key    = r_cell_key;
    assign o_start_index = r_start;
    assign o_status      = r_status;

    assign err_fields_zero = (o_particle == 10'd0) && (o_cell_key == 12'd0) &&
                             (o_start_index == 11'd0);
    assign div_consumer    = (r_state == S_DIV) || (r_state == S_MOD);

    `SHG_ASSERT_NOW(a_err_zero, o_strobe && o_status, err_fields_zero, "error result carries data")
    `SHG_ASSERT_NOW(a_div_use, div_out.valid, div_consumer, "divider result with no consumer")
    `SHG_ASSERT_NEXT(a_build_done, (r_state == S_PLC_C) && last_n, r_state == S_DONE, "build stuck")
endmodule
